/* src/lad_pkg.sv */
`timescale 1ns / 1ps

package lad_pkg;

	// storage geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP_W = 5;
	localparam int DATA_W = 32;
	// compare width wide enough for the index, the capacity and DEPTH itself
	localparam int CMP_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// access codes
	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	// result codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // capture the accepted request
		logic run;    // execute it and load the result register
	} lad_cmd_t;

endpackage

/* src/lad_datapath.sv */
`timescale 1ns / 1ps

module lad_datapath
	import lad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lad_cmd_t          cmd,
	input  logic              cfg_wr_en,
	input  logic [CAP_W-1:0]  cfg_wr_data,
	input  logic [1:0]        op,
	input  logic [DATA_W-1:0] value,
	output logic [DATA_W-1:0] popped_value,
	output logic [1:0]        status
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [CAP_W-1:0]  cap_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic              empty_q;
	op_t               op_q;
	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] popped_q;
	status_t           status_q;

	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  last_slot;
	status_t           res_status;
	logic              do_write;
	logic              do_read;
	logic [IDX_W-1:0]  wr_idx;
	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  head_d;
	logic [IDX_W-1:0]  tail_d;
	logic              empty_d;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(op);
			value_q <= value;
		end
	end

	// last usable slot: zero acts as one, above depth acts as depth
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_ext == '0) begin
			last_slot = '0;
		end else if (cap_ext > CMP_W'(DEPTH)) begin
			last_slot = CMP_W'(DEPTH - 1);
		end else begin
			last_slot = cap_ext - CMP_W'(1);
		end
	end

	// access decision and pointer update
	always_comb begin
		res_status = ST_OK;
		do_write   = 1'b0;
		do_read    = 1'b0;
		wr_idx     = '0;
		rd_idx     = head_q;
		head_d     = head_q;
		tail_d     = tail_q;
		empty_d    = empty_q;
		unique case (op_q)
			OP_PUSH_BACK: begin
				if (empty_q) begin
					do_write = 1'b1;
					head_d   = '0;
					tail_d   = '0;
					empty_d  = 1'b0;
				end else if (CMP_W'(tail_q) >= last_slot) begin
					res_status = ST_FULL;
				end else begin
					do_write = 1'b1;
					wr_idx   = tail_q + IDX_W'(1);
					tail_d   = tail_q + IDX_W'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (empty_q) begin
					do_write = 1'b1;
					head_d   = '0;
					tail_d   = '0;
					empty_d  = 1'b0;
				end else if (head_q == '0) begin
					res_status = ST_FULL;
				end else begin
					do_write = 1'b1;
					wr_idx   = head_q - IDX_W'(1);
					head_d   = head_q - IDX_W'(1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				rd_idx = (op_q == OP_POP_FRONT) ? head_q : tail_q;
				if (empty_q) begin
					res_status = ST_EMPTY;
				end else begin
					do_read = 1'b1;
					if (head_q == tail_q) begin
						head_d  = '0;
						tail_d  = '0;
						empty_d = 1'b1;
					end else if (op_q == OP_POP_FRONT) begin
						head_d = head_q + IDX_W'(1);
					end else begin
						tail_d = tail_q - IDX_W'(1);
					end
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.run) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
		end
	end

	// entry store with registered read into the result register
	always_ff @(posedge clk) begin
		if (cmd.run) begin
			if (do_write) begin
				mem_q[wr_idx] <= value_q;
			end
			popped_q <= do_read ? mem_q[rd_idx] : '0;
			status_q <= res_status;
		end
	end

	assign popped_value = popped_q;
	assign status       = status_q;

endmodule

/* src/lad_ctrl.sv */
`timescale 1ns / 1ps

module lad_ctrl
	import lad_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output lad_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   run_go;

	// execute once the result register is free or being drained
	assign run_go   = (state_q == S_RUN) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE);
	assign cmd      = '{load: in_valid && (state_q == S_IDLE), run: run_go};

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
					end
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_RUN: begin
					if (run_go) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/linear_array_deque.sv */
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in        input      in_valid / in_ready  op, value
// out       output     out_valid/out_ready  popped_value, status
// cfg       input      cfg_wr_en            cfg_wr_data (capacity)
//
// each request is captured in S_IDLE, then executed in S_RUN, which updates
// the pointers and accesses the entry store (one port, registered read)
// a new request is taken the cycle after the previous one executes
// asynchronous active-low reset empties the deque and sets capacity to 16
// a stalled result holds the execute cycle of the next request only

module linear_array_deque
	import lad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CAP_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [DATA_W-1:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] popped_value,
	output logic [1:0]        status
);

	lad_cmd_t cmd;

	lad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	lad_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.op           (op),
		.value        (value),
		.popped_value (popped_value),
		.status       (status)
	);

endmodule

/* src/lad_checker.sv */
`timescale 1ns / 1ps

module lad_checker
	import lad_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] popped_value,
	input logic [1:0]        status
);

	// one request in flight: no accept directly after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
	else $error("request accepted back to back");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(popped_value)
			&& $stable(status)))
	else $error("stalled result changed");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
	else $error("undefined status code");

	// failures carry a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL || status == ST_EMPTY)) |-> (popped_value == '0))
	else $error("failed request with non-zero value");

endmodule

bind linear_array_deque lad_checker u_lad_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.popped_value (popped_value),
	.status       (status)
);

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
	import lad_pkg::*;

	localparam int STALL_LIMIT = 4000;   // cycles with no request or result moving
	localparam int HOLD_CYCLES = 250;    // long receiver hold-off to back the block up
	localparam int PHASE_ITEMS = 157;

	typedef struct packed {
		logic [DATA_W-1:0] popped;
		status_t           code;
	} deque_result_t;

	// mirror of the deque that predicts the result of every request
	class deque_tracker;
		logic [DATA_W-1:0] slots [DEPTH];
		int unsigned       head = 0;
		int unsigned       tail = 0;
		bit                vacant = 1'b1;
		logic [CAP_W-1:0]  cap = CAP_RESET;
		deque_result_t     awaited [$];
		int                errors = 0;
		int                accepted = 0;
		int                op_seen [4];
		int                status_seen [3];

		function void note_capacity(logic [CAP_W-1:0] c);
			cap = c;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int unsigned usable();
			if (cap == 0)
				return 1;
			if (cap > DEPTH)
				return DEPTH;
			return cap;
		endfunction

		// apply one request to the mirror and queue the result it must give
		function void note_request(logic [1:0] raw_op, logic [DATA_W-1:0] v);
			deque_result_t r;
			r.popped = '0;
			r.code = ST_OK;
			accepted++;
			op_seen[raw_op]++;
			case (op_t'(raw_op))
				OP_PUSH_BACK: begin
					if (vacant) begin
						head = 0;
						tail = 0;
						vacant = 1'b0;
						slots[0] = v;
					end else if (tail >= usable() - 1) begin
						r.code = ST_FULL;
					end else begin
						tail++;
						slots[tail] = v;
					end
				end
				OP_PUSH_FRONT: begin
					if (vacant) begin
						head = 0;
						tail = 0;
						vacant = 1'b0;
						slots[0] = v;
					end else if (head == 0) begin
						r.code = ST_FULL;
					end else begin
						head--;
						slots[head] = v;
					end
				end
				OP_POP_FRONT: begin
					if (vacant) begin
						r.code = ST_EMPTY;
					end else begin
						r.popped = slots[head];
						if (head == tail) begin
							head = 0;
							tail = 0;
							vacant = 1'b1;
						end else begin
							head++;
						end
					end
				end
				default: begin
					if (vacant) begin
						r.code = ST_EMPTY;
					end else begin
						r.popped = slots[tail];
						if (head == tail) begin
							head = 0;
							tail = 0;
							vacant = 1'b1;
						end else begin
							tail--;
						end
					end
				end
			endcase
			awaited.push_back(r);
		endfunction

		// compare one delivered result with the oldest prediction
		function void check_result(logic [DATA_W-1:0] pv, logic [1:0] st);
			deque_result_t want;
			if (st < 3)
				status_seen[st]++;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result popped_value %h status %0d", $time, pv, st);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (pv !== want.popped) begin
				$display("%0t: popped_value expected %h actual %h", $time, want.popped, pv);
				errors++;
			end
			if (st !== want.code) begin
				$display("%0t: status expected %0d actual %0d", $time, want.code, st);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CAP_W-1:0]  cfg_wr_data;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        op;
	logic [DATA_W-1:0] value;
	logic              out_valid;
	logic              out_ready;
	logic [DATA_W-1:0] popped_value;
	logic [1:0]        status;

	deque_tracker book = new();
	bit           quiet = 1'b0;     // no idling on either side
	bit           held_once = 1'b0;
	int           still_cycles = 0;

	linear_array_deque uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.popped_value (popped_value),
		.status       (status)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// observe both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			still_cycles++;
			if (in_valid && in_ready) begin
				book.note_request(op, value);
				still_cycles = 0;
			end
			if (out_valid && out_ready) begin
				book.check_result(popped_value, status);
				still_cycles = 0;
			end
			if (still_cycles >= STALL_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, still_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off while requests keep coming
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			if (!held_once && !quiet && book.accepted >= 300 && in_valid) begin
				held_once = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// offer one request and hold it until it is taken
	task automatic offer(input op_t code, input logic [DATA_W-1:0] v);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		value <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// write capacity once the block has drained
	task automatic set_capacity(input logic [CAP_W-1:0] c);
		in_valid <= 1'b0;
		// let the monitor log the last accepted request first
		@(posedge clk);
		while (book.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		book.note_capacity(c);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// random requests, swinging between filling and draining the deque
	task automatic random_phase(input int count);
		int push_pct;
		op_t code;
		push_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 80;
					1: push_pct = 50;
					default: push_pct = 20;
				endcase
			end
			if ($urandom_range(0, 99) < push_pct)
				code = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else
				code = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
			offer(code, pick_value());
		end
	endtask

	// stimulus
	initial begin
		logic [CAP_W-1:0] caps [7];
		caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd2, 5'd1, 5'd16};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		op = OP_PUSH_BACK;
		value = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, front push into slot zero, both ends, extremes
		offer(OP_POP_FRONT, 32'h0000_0000);
		offer(OP_POP_BACK, 32'hFFFF_FFFF);
		offer(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		offer(OP_PUSH_FRONT, 32'h0000_0001);
		offer(OP_PUSH_BACK, 32'h8000_0000);
		offer(OP_PUSH_BACK, 32'hFFFF_FFFF);
		offer(OP_PUSH_BACK, 32'h0000_0000);
		offer(OP_POP_BACK, 32'h0000_0000);
		offer(OP_POP_FRONT, 32'h0000_0000);
		offer(OP_PUSH_FRONT, 32'h1234_5678);
		offer(OP_POP_FRONT, 32'h0000_0000);
		offer(OP_POP_FRONT, 32'h0000_0000);
		offer(OP_POP_BACK, 32'h0000_0000);
		offer(OP_POP_BACK, 32'h0000_0000);

		// directed: single slot, both ends refuse, last entry empties
		set_capacity(5'd1);
		offer(OP_PUSH_BACK, 32'h5A5A_5A5A);
		offer(OP_PUSH_BACK, 32'h0000_0001);
		offer(OP_PUSH_FRONT, 32'h0000_0002);
		offer(OP_POP_FRONT, 32'h0000_0000);
		offer(OP_PUSH_BACK, 32'hA5A5_A5A5);
		offer(OP_POP_BACK, 32'h0000_0000);

		// random phases; capacity changes may leave entries beyond the new limit
		for (int p = 0; p < 7; p++) begin
			set_capacity(caps[p]);
			if (p == 6)
				quiet = 1'b1;
			random_phase(PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("requests: %0d push back, %0d push front, %0d pop front, %0d pop back",
			book.op_seen[0], book.op_seen[1], book.op_seen[2], book.op_seen[3]);
		$display("results: %0d ok, %0d no room, %0d empty; capacities 16 1 3 0 31 2",
			book.status_seen[0], book.status_seen[1], book.status_seen[2]);
		if (book.errors == 0 && book.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
